// ===== rtl/core/binary_max_heap_queue_defines.svh =====
// Assertion macros for the binary max-heap priority queue.
// Included by RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BMHQ_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bmhq_pkg.sv =====
// Shared types and constants for the binary max-heap priority queue.
// No dependencies; used by bmhq_seq and binary_max_heap_queue.
package bmhq_pkg;

  localparam int VALUE_W     = 32;
  localparam int SWAP_W      = 3;
  localparam int TOTAL_W     = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                       command;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [SWAP_W-1:0]          swap_count;
    status_t                    status;
    logic signed [VALUE_W-1:0]  top_value;
    logic [TOTAL_W-1:0]         entry_total;
  } res_t;

  typedef struct packed {
    logic idle;
    logic done;
    res_t res;
  } seq_rsp_t;

endpackage

// ===== rtl/core/bmhq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bmhq_seq.sv =====
// Heap sequencer: sift-up / sift-down over the heap RAM with one shared comparator.
// Depends on bmhq_pkg, bmhq_ram and binary_max_heap_queue_defines.svh.
`include "binary_max_heap_queue_defines.svh"

module bmhq_seq #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bmhq_pkg::req_t     req,
  input  logic               out_free,
  output bmhq_pkg::seq_rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int IW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RM_LAST,
    S_DN_RL,
    S_DN_CL,
    S_DN_CR,
    S_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  logic [IW-1:0]                  cnt_r, cnt_nxt;
  logic [IW-1:0]                  node_r, node_nxt;
  logic [IW-1:0]                  child_r, child_nxt;
  logic [IW-1:0]                  best_r, best_nxt;
  logic                           rok_r, rok_nxt;
  logic signed [DATA_WIDTH-1:0]   v_r, v_nxt;
  logic signed [DATA_WIDTH-1:0]   cand_r, cand_nxt;
  logic signed [DATA_WIDTH-1:0]   top_r, top_nxt;
  logic [bmhq_pkg::SWAP_W-1:0]    swap_r, swap_nxt;
  bmhq_pkg::status_t              status_r, status_nxt;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0]          ram_wdata, ram_rdata;

  logic [DATA_WIDTH-1:0]          cmp_a, cmp_b;
  logic                           cmp_gt;
  logic [IW:0]                    lchild_w, cnt_ext, rchild_w;
  logic                           take_r;
  logic [IW-1:0]                  best_idx;
  logic [DATA_WIDTH-1:0]          best_val;

  bmhq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared signed comparator: cmp_gt = a > b.
  always_comb begin
    case (state_r)
      S_DN_CL: begin
        cmp_a = ram_rdata;
        cmp_b = v_r;
      end
      S_DN_CR: begin
        cmp_a = ram_rdata;
        cmp_b = cand_r;
      end
      default: begin
        cmp_a = v_r;
        cmp_b = ram_rdata;
      end
    endcase
  end

  assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

  assign lchild_w = {node_r, 1'b0};
  assign cnt_ext  = {1'b0, cnt_r};
  assign rchild_w = {1'b0, child_r} + 1'b1;
  assign take_r   = rok_r && cmp_gt;
  assign best_idx = take_r ? IW'(rchild_w) : best_r;
  assign best_val = take_r ? ram_rdata : cand_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    node_nxt   = node_r;
    child_nxt  = child_r;
    best_nxt   = best_r;
    rok_nxt    = rok_r;
    v_nxt      = v_r;
    cand_nxt   = cand_r;
    swap_nxt   = swap_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_waddr  = AW'(node_r - 1'b1);
    ram_wdata  = v_r;
    ram_raddr  = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          swap_nxt   = '0;
          status_nxt = bmhq_pkg::ST_DONE;
          v_nxt      = DATA_WIDTH'(req.value);
          if (req.command == bmhq_pkg::CMD_INSERT) begin
            if (cnt_r == IW'(CAPACITY)) begin
              status_nxt = bmhq_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              cnt_nxt   = cnt_r + 1'b1;
              node_nxt  = cnt_r + 1'b1;
              state_nxt = S_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = bmhq_pkg::ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              ram_raddr = AW'(cnt_r - 1'b1);
              state_nxt = S_RM_LAST;
            end
          end
        end
      end
      S_UP_RD: begin
        if (node_r == IW'(1)) begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ram_raddr = AW'((node_r >> 1) - 1'b1);
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (cmp_gt) begin
          // parent moves down into the hole
          ram_wdata = ram_rdata;
          node_nxt  = node_r >> 1;
          swap_nxt  = swap_r + 1'b1;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RM_LAST: begin
        v_nxt     = ram_rdata;
        cnt_nxt   = cnt_r - 1'b1;
        node_nxt  = IW'(1);
        state_nxt = (cnt_r == IW'(1)) ? S_DONE : S_DN_RL;
      end
      S_DN_RL: begin
        if (lchild_w > cnt_ext) begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ram_raddr = AW'(lchild_w - 1'b1);
          child_nxt = IW'(lchild_w);
          state_nxt = S_DN_CL;
        end
      end
      S_DN_CL: begin
        if (cmp_gt) begin
          cand_nxt = ram_rdata;
          best_nxt = child_r;
        end else begin
          cand_nxt = v_r;
          best_nxt = node_r;
        end
        rok_nxt   = rchild_w <= cnt_ext;
        ram_raddr = AW'(child_r);
        state_nxt = S_DN_CR;
      end
      S_DN_CR: begin
        ram_we = 1'b1;
        if (best_idx == node_r) begin
          state_nxt = S_DONE;
        end else begin
          ram_wdata = best_val;
          node_nxt  = best_idx;
          state_nxt = S_DN_RL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Root value tracked from writes to slot 1.
  assign top_nxt = (ram_we && ram_waddr == '0) ? ram_wdata : top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    node_r   <= node_nxt;
    child_r  <= child_nxt;
    best_r   <= best_nxt;
    rok_r    <= rok_nxt;
    v_r      <= v_nxt;
    cand_r   <= cand_nxt;
    top_r    <= top_nxt;
    swap_r   <= swap_nxt;
    status_r <= status_nxt;
  end

  assign rsp.idle               = (state_r == S_IDLE);
  assign rsp.done               = (state_r == S_DONE);
  assign rsp.res.swap_count     = swap_r;
  assign rsp.res.status         = status_r;
  assign rsp.res.top_value      = (cnt_r == '0) ? '0 : bmhq_pkg::VALUE_W'(top_r);
  assign rsp.res.entry_total    = bmhq_pkg::TOTAL_W'(cnt_r);

  `BMHQ_ASSERT(a_cnt_cap, 1'b1, cnt_r <= IW'(CAPACITY), "entry count above capacity")
  `BMHQ_ASSERT(a_cnt_step, cnt_r != $past(cnt_r), (cnt_r == $past(cnt_r) + 1'b1) || (cnt_r + 1'b1 == $past(cnt_r)), "entry count moved by more than one")
  `BMHQ_ASSERT(a_we_state, ram_we, (state_r == S_UP_RD) || (state_r == S_UP_CMP) || (state_r == S_DN_RL) || (state_r == S_DN_CR), "heap write outside sift")
  `BMHQ_ASSERT(a_node_rng, (state_r == S_UP_CMP) || (state_r == S_DN_CR), (node_r != '0) && (node_r <= cnt_r), "sift node out of range")
  `BMHQ_ASSERT_NEXT(a_done_hold, (state_r == S_DONE) && !out_free, state_r == S_DONE, "result dropped while output busy")

endmodule

// ===== rtl/core/binary_max_heap_queue.sv =====
// Binary max-heap priority queue, one result transaction per command.
// Only one command is in flight; a new command is accepted once the sequencer is idle again.
// in_tready is high only while the sequencer is idle; a result waiting in the output
// register does not block the next command until that command finishes.
// Reset (rst_n low, synchronous) empties the queue; heap RAM contents are not cleared.
module binary_max_heap_queue #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bmhq_pkg::IN_TDATA_W-1:0]     in_tdata,   // [31:0] value
  input  logic                                in_tuser,   // [0] command
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bmhq_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [2:0] swap_count, [34:3] top_value,
                                                          // [41:35] entry_total, [47:42] zero
  output logic [1:0]                          out_tuser   // [1:0] status
);

  bmhq_pkg::req_t     req;
  bmhq_pkg::seq_rsp_t rsp;
  bmhq_pkg::res_t     out_res_r;
  logic               out_tvalid_r;
  logic               out_free;
  logic               start;

  assign in_tready = rsp.idle;
  assign start     = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign req.command = bmhq_pkg::cmd_t'(in_tuser);
  assign req.value   = in_tdata;

  bmhq_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (req),
    .out_free (out_free),
    .rsp      (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (rsp.done && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (rsp.done && out_free) begin
      out_res_r <= rsp.res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, out_res_r.entry_total, out_res_r.top_value,
                       out_res_r.swap_count};
  assign out_tuser  = out_res_r.status;

endmodule
